// File: design/smbf_pkg.sv
// Shared types, constants and helper functions for the scored move picker.
`default_nettype none

package smbf_pkg;

    // Default list depth
    localparam int MAX_MOVES_DEFAULT = 256;

    // Register map
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_MOVE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILLER_FIRST    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KILLER_SECOND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KILLERS_PRESENT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_MOVE    = 3'd4;

    // Score bands
    localparam logic signed [31:0] SCORE_HASH       = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SCORE_WIN_BASE   = 32'sd2;
    localparam logic signed [31:0] KILLER_SCORE     = 32'sd1;
    localparam logic signed [31:0] SCORE_COUNTER    = 32'sd0;
    localparam logic signed [31:0] SCORE_QUIET_BASE = -32'sd65537;
    localparam logic signed [31:0] SCORE_LOSS_BASE  = -32'sd131073;

    // Stored word: move in the upper half, score in the lower half
    localparam int WORD_W = 64;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TAKE   = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DELIVERED = 2'd1,
        STAT_EXHAUSTED = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2
    } state_t;

    typedef struct packed {
        logic [31:0] hash_move;
        logic [31:0] killer_first;
        logic [31:0] killer_second;
        logic        killers_present;
        logic [31:0] counter_move;
    } cfg_t;

    // Map a score back to its exchange value, saturated to 16 bits
    function automatic logic signed [15:0] score_to_exchange(input logic signed [31:0] s);
        logic signed [32:0] e;
        logic signed [15:0] r;
        if (s > 32'sd0)
            e = 33'(s) - 33'sd2;
        else
            e = 33'(s) + 33'sd131073;
        if (e > 33'sd32767)
            r = 16'sh7FFF;
        else if (e < -33'sd32768)
            r = 16'sh8000;
        else
            r = 16'(e);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/smbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module smbf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/smbf_score.sv
// Priority scoring of an appended move.
`default_nettype none

module smbf_score (
    input  wire smbf_pkg::cfg_t       cfg,
    input  wire logic [31:0]          move_code,
    input  wire logic                 is_capture,
    input  wire logic signed [15:0]   exchange_value,
    input  wire logic signed [16:0]   history_value,
    output logic signed [31:0]        score
);

    logic signed [31:0] exch_ext;
    logic signed [31:0] hist_ext;
    logic               is_killer;

    assign exch_ext  = 32'(exchange_value);
    assign hist_ext  = 32'(history_value);
    assign is_killer = cfg.killers_present
                       && ((move_code == cfg.killer_first) || (move_code == cfg.killer_second));

    // Hash move first, then captures, killers, counter move, quiet moves
    always_comb
    begin
        if (move_code == cfg.hash_move)
            score = smbf_pkg::SCORE_HASH;
        else if (is_capture)
            score = (exchange_value >= 16'sd0) ? smbf_pkg::SCORE_WIN_BASE + exch_ext
                                               : smbf_pkg::SCORE_LOSS_BASE + exch_ext;
        else if (is_killer)
            score = smbf_pkg::KILLER_SCORE;
        else if (move_code == cfg.counter_move)
            score = smbf_pkg::SCORE_COUNTER;
        else
            score = smbf_pkg::SCORE_QUIET_BASE + hist_ext;
    end

endmodule

`default_nettype wire

// File: design/scored_move_best_first_picker.sv
// Clear, append: result word one cycle after acceptance; one word per cycle at best.
// Take with k unread slots: the scan reads the k slots, one stored slot per cycle
// through the single read port of the move RAM. Next word is taken once the take
// has written back; the write-back waits until the output register is free.
// Reset clears the list count, read pointer, registers and handshake; RAM contents
// are left as they are and only slots written since a clear are ever read.
`default_nettype none

module scored_move_best_first_picker #(
    parameter int MAX_MOVES = smbf_pkg::MAX_MOVES_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration
    input  wire logic                               cfg_we,
    input  wire logic [smbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         command,
    input  wire logic [31:0]                        move_code,
    input  wire logic                               is_capture,
    input  wire logic signed [15:0]                 exchange_value,
    input  wire logic signed [16:0]                 history_value,
    // output channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              status,
    output logic [31:0]                             best_move,
    output logic signed [31:0]                      best_score,
    output logic signed [15:0]                      recovered_exchange
);

    localparam int AW = $clog2(MAX_MOVES);
    localparam int CW = $clog2(MAX_MOVES + 1);
    localparam logic [CW-1:0] LIST_MAX = CW'(MAX_MOVES);

    // Control state
    smbf_pkg::state_t  state_reg, state_next;
    smbf_pkg::cfg_t    cfg_reg;
    logic [CW-1:0]     list_count_reg, list_count_next;
    logic [CW-1:0]     next_slot_reg, next_slot_next;
    logic              out_valid_reg, out_valid_next;

    // Scan datapath
    logic [AW-1:0]              data_idx_reg, data_idx_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;
    logic signed [31:0]         best_score_reg, best_score_next;
    logic [31:0]                best_move_reg, best_move_next;
    logic [smbf_pkg::WORD_W-1:0] first_word_reg, first_word_next;

    // Result word
    smbf_pkg::status_t  res_status_reg, res_status_next;
    logic [31:0]        res_move_reg, res_move_next;
    logic signed [31:0] res_score_reg, res_score_next;
    logic signed [15:0] res_exch_reg, res_exch_next;

    // RAM port
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [smbf_pkg::WORD_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [smbf_pkg::WORD_W-1:0] ram_rdata;

    logic               accept;
    logic               out_free;
    logic               list_full;
    logic               has_unread;
    logic               scan_first;
    logic               scan_better;
    logic               scan_last;
    logic signed [31:0] scan_score;
    logic signed [31:0] new_score;
    smbf_pkg::cmd_t     cmd;

    assign cmd        = smbf_pkg::cmd_t'(command);
    assign out_free   = !out_valid_reg || out_ready;
    assign accept     = in_valid && in_ready;
    assign list_full  = (list_count_reg >= LIST_MAX);
    assign has_unread = (next_slot_reg < list_count_reg);

    // Compare stage on the word just read
    assign scan_score  = signed'(ram_rdata[31:0]);
    assign scan_first  = (data_idx_reg == next_slot_reg[AW-1:0]);
    assign scan_better = scan_first || (scan_score > best_score_reg);
    assign scan_last   = ((CW'(data_idx_reg) + CW'(1)) == list_count_reg);

    smbf_score u_score (
        .cfg            (cfg_reg),
        .move_code      (move_code),
        .is_capture     (is_capture),
        .exchange_value (exchange_value),
        .history_value  (history_value),
        .score          (new_score)
    );

    smbf_ram #(
        .WIDTH (smbf_pkg::WORD_W),
        .DEPTH (MAX_MOVES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                smbf_pkg::REG_HASH_MOVE:       cfg_reg.hash_move       <= cfg_data;
                smbf_pkg::REG_KILLER_FIRST:    cfg_reg.killer_first    <= cfg_data;
                smbf_pkg::REG_KILLER_SECOND:   cfg_reg.killer_second   <= cfg_data;
                smbf_pkg::REG_KILLERS_PRESENT: cfg_reg.killers_present <= cfg_data[0];
                smbf_pkg::REG_COUNTER_MOVE:    cfg_reg.counter_move    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smbf_pkg::ST_IDLE:
            begin
                if (accept && cmd == smbf_pkg::CMD_TAKE && has_unread)
                    state_next = smbf_pkg::ST_SCAN;
            end
            smbf_pkg::ST_SCAN:
            begin
                if (scan_last)
                    state_next = smbf_pkg::ST_WRITE;
            end
            smbf_pkg::ST_WRITE:
            begin
                if (out_free)
                    state_next = smbf_pkg::ST_IDLE;
            end
            default: state_next = smbf_pkg::ST_IDLE;
        endcase
    end

    // FSM outputs: handshake and RAM port
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = list_count_reg[AW-1:0];
        ram_wdata = {move_code, new_score};
        ram_raddr = data_idx_reg + AW'(1);
        unique case (state_reg)
            smbf_pkg::ST_IDLE:
            begin
                in_ready  = out_free;
                ram_raddr = next_slot_reg[AW-1:0];
                ram_we    = accept && cmd == smbf_pkg::CMD_APPEND && !list_full;
            end
            smbf_pkg::ST_SCAN: ;
            smbf_pkg::ST_WRITE:
            begin
                // winner's slot takes the first unread word
                ram_we    = out_free;
                ram_waddr = best_idx_reg;
                ram_wdata = first_word_reg;
            end
            default: ;
        endcase
    end

    // Datapath and result next values
    always_comb
    begin
        list_count_next = list_count_reg;
        next_slot_next  = next_slot_reg;
        data_idx_next   = data_idx_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        best_move_next  = best_move_reg;
        first_word_next = first_word_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        res_status_next = res_status_reg;
        res_move_next   = res_move_reg;
        res_score_next  = res_score_reg;
        res_exch_next   = res_exch_reg;

        unique case (state_reg)
            smbf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = smbf_pkg::STAT_OK;
                    res_move_next   = '0;
                    res_score_next  = '0;
                    res_exch_next   = '0;
                    out_valid_next  = 1'b1;
                    unique case (cmd)
                        smbf_pkg::CMD_CLEAR:
                        begin
                            list_count_next = '0;
                            next_slot_next  = '0;
                        end
                        smbf_pkg::CMD_APPEND:
                        begin
                            if (list_full)
                                res_status_next = smbf_pkg::STAT_FULL;
                            else
                                list_count_next = list_count_reg + CW'(1);
                        end
                        smbf_pkg::CMD_TAKE:
                        begin
                            if (has_unread)
                            begin
                                out_valid_next = 1'b0;
                                data_idx_next  = next_slot_reg[AW-1:0];
                            end
                            else
                            begin
                                res_status_next = smbf_pkg::STAT_EXHAUSTED;
                            end
                        end
                        smbf_pkg::CMD_NOP: ;
                        default: ;
                    endcase
                end
            end
            smbf_pkg::ST_SCAN:
            begin
                data_idx_next = data_idx_reg + AW'(1);
                if (scan_first)
                    first_word_next = ram_rdata;
                if (scan_better)
                begin
                    best_idx_next   = data_idx_reg;
                    best_score_next = scan_score;
                    best_move_next  = ram_rdata[63:32];
                end
            end
            smbf_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    next_slot_next  = next_slot_reg + CW'(1);
                    out_valid_next  = 1'b1;
                    res_status_next = smbf_pkg::STAT_DELIVERED;
                    res_move_next   = best_move_reg;
                    res_score_next  = best_score_reg;
                    res_exch_next   = smbf_pkg::score_to_exchange(best_score_reg);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smbf_pkg::ST_IDLE;
            list_count_reg <= '0;
            next_slot_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            list_count_reg <= list_count_next;
            next_slot_reg  <= next_slot_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_idx_reg   <= data_idx_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        best_move_reg  <= best_move_next;
        first_word_reg <= first_word_next;
        res_status_reg <= res_status_next;
        res_move_reg   <= res_move_next;
        res_score_reg  <= res_score_next;
        res_exch_reg   <= res_exch_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = res_status_reg;
    assign best_move          = res_move_reg;
    assign best_score         = res_score_reg;
    assign recovered_exchange = res_exch_reg;

endmodule

`default_nettype wire

// File: tb/sv/smbf_pick_monitor.sv
// Monitor for the scored move picker: predicts every result word and compares it.
`timescale 1ns / 100ps

module smbf_pick_monitor #(
    parameter int MOVE_CAP = smbf_pkg::MAX_MOVES_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [smbf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [smbf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic [1:0]                          command,
    input  wire logic [31:0]                         move_code,
    input  wire logic                                is_capture,
    input  wire logic signed [15:0]                  exchange_value,
    input  wire logic signed [16:0]                  history_value,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic [1:0]                          status,
    input  wire logic [31:0]                         best_move,
    input  wire logic signed [31:0]                  best_score,
    input  wire logic signed [15:0]                  recovered_exchange,
    output int                                       mismatches,
    output int                                       pending,
    output int                                       delivered_seen,
    output int                                       exhausted_seen,
    output int                                       full_seen
);
    import smbf_pkg::*;

    localparam int PRINT_CAP = 50;

    // One expected result word
    typedef struct packed {
        status_t            st;
        logic [31:0]        mv;
        logic signed [31:0] sc;
        logic signed [15:0] xc;
    } pick_word_t;

    // Shadow registers and list contents
    cfg_t               regs_q;
    logic [31:0]        mv_mem [MOVE_CAP];
    logic signed [31:0] sc_mem [MOVE_CAP];
    int                 fill_cnt;
    int                 rd_ptr;
    pick_word_t         due_words [$];

    // Priority of a move as it is appended
    function automatic logic signed [31:0] rank_move(logic [31:0] mv, logic cap,
                                                     logic signed [15:0] ex,
                                                     logic signed [16:0] hist);
        logic signed [31:0] s;
        if (mv == regs_q.hash_move)
            s = SCORE_HASH;
        else if (cap)
            s = (ex >= 0) ? SCORE_WIN_BASE + ex : SCORE_LOSS_BASE + ex;
        else if (regs_q.killers_present &&
                 (mv == regs_q.killer_first || mv == regs_q.killer_second))
            s = KILLER_SCORE;
        else if (mv == regs_q.counter_move)
            s = SCORE_COUNTER;
        else
            s = SCORE_QUIET_BASE + hist;
        return s;
    endfunction

    // Exchange value implied by a score, clipped to 16 bits
    function automatic logic signed [15:0] exchange_from_rank(logic signed [31:0] s);
        longint e;
        if (s > 0)
            e = longint'(s) - longint'(SCORE_WIN_BASE);
        else
            e = longint'(s) - longint'(SCORE_LOSS_BASE);
        if (e > 32767)
            e = 32767;
        else if (e < -32768)
            e = -32768;
        return e[15:0];
    endfunction

    // Apply one command to the shadow list and give the word it should produce
    function automatic pick_word_t advance_list(cmd_t c, logic [31:0] mv, logic cap,
                                                logic signed [15:0] ex,
                                                logic signed [16:0] hist);
        pick_word_t r;
        int         win;
        r = '0;
        r.st = STAT_OK;
        case (c)
            CMD_CLEAR:
            begin
                fill_cnt = 0;
                rd_ptr = 0;
            end
            CMD_APPEND:
            begin
                if (fill_cnt >= MOVE_CAP)
                    r.st = STAT_FULL;
                else
                begin
                    mv_mem[fill_cnt] = mv;
                    sc_mem[fill_cnt] = rank_move(mv, cap, ex, hist);
                    fill_cnt++;
                end
            end
            CMD_TAKE:
            begin
                if (rd_ptr >= fill_cnt)
                    r.st = STAT_EXHAUSTED;
                else
                begin
                    // highest score wins, lowest slot on a tie
                    win = rd_ptr;
                    for (int i = rd_ptr + 1; i < fill_cnt; i++)
                        if (sc_mem[i] > sc_mem[win])
                            win = i;
                    r.st = STAT_DELIVERED;
                    r.mv = mv_mem[win];
                    r.sc = sc_mem[win];
                    r.xc = exchange_from_rank(sc_mem[win]);
                    // first unread slot moves into the winner's place
                    mv_mem[win] = mv_mem[rd_ptr];
                    sc_mem[win] = sc_mem[rd_ptr];
                    rd_ptr++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        if (mismatches < PRINT_CAP)
            $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    // Watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        pick_word_t want;
        if (!rst_n)
        begin
            regs_q = '0;
            fill_cnt = 0;
            rd_ptr = 0;
            due_words.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_HASH_MOVE:       regs_q.hash_move = cfg_data;
                    REG_KILLER_FIRST:    regs_q.killer_first = cfg_data;
                    REG_KILLER_SECOND:   regs_q.killer_second = cfg_data;
                    REG_KILLERS_PRESENT: regs_q.killers_present = cfg_data[0];
                    REG_COUNTER_MOVE:    regs_q.counter_move = cfg_data;
                    default: ;
                endcase
            end
            // result word leaving the block
            if (out_valid && out_ready)
            begin
                if (due_words.size() == 0)
                    flag_mismatch("word with nothing awaited, status", '0, status);
                else
                begin
                    want = due_words.pop_front();
                    case (want.st)
                        STAT_DELIVERED: delivered_seen++;
                        STAT_EXHAUSTED: exhausted_seen++;
                        STAT_FULL:      full_seen++;
                        default: ;
                    endcase
                    if (status !== want.st)
                        flag_mismatch("status", want.st, status);
                    if (best_move !== want.mv)
                        flag_mismatch("best_move", want.mv, best_move);
                    if (best_score !== want.sc)
                        flag_mismatch("best_score", want.sc, best_score);
                    if (recovered_exchange !== want.xc)
                        flag_mismatch("recovered_exchange", want.xc, recovered_exchange);
                end
            end
            // command word entering the block
            if (in_valid && in_ready)
                due_words.push_back(advance_list(cmd_t'(command), move_code, is_capture,
                                                 exchange_value, history_value));
            pending = due_words.size();
        end
    end

endmodule

// File: tb/sv/tb_scored_move_best_first_picker.sv
// Top of the scored move picker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_scored_move_best_first_picker;
    import smbf_pkg::*;

    localparam int LIST_DEPTH    = MAX_MOVES_DEFAULT;
    localparam int ITEM_TARGET   = 2000;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = LIST_DEPTH + 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AT_WORD  = 600;
    localparam int CYCLE_LIMIT   = 3_000_000;
    // unmapped register index, written to show it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [1:0]               command;
    logic [31:0]              move_code;
    logic                     is_capture;
    logic signed [15:0]       exchange_value;
    logic signed [16:0]       history_value;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic [31:0]              best_move;
    logic signed [31:0]       best_score;
    logic signed [15:0]       recovered_exchange;

    int   mismatches;
    int   pending;
    int   delivered_seen;
    int   exhausted_seen;
    int   full_seen;

    cfg_t cur_regs;
    int   items_sent;
    bit   tx_quiet;
    int   cycle_count;
    int   words_taken;
    int   rx_gap;
    bit   rx_quiet;

    scored_move_best_first_picker uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .move_code          (move_code),
        .is_capture         (is_capture),
        .exchange_value     (exchange_value),
        .history_value      (history_value),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .best_move          (best_move),
        .best_score         (best_score),
        .recovered_exchange (recovered_exchange)
    );

    smbf_pick_monitor #(.MOVE_CAP(LIST_DEPTH)) pick_mon (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .command            (command),
        .move_code          (move_code),
        .is_capture         (is_capture),
        .exchange_value     (exchange_value),
        .history_value      (history_value),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .best_move          (best_move),
        .best_score         (best_score),
        .recovered_exchange (recovered_exchange),
        .mismatches         (mismatches),
        .pending            (pending),
        .delivered_seen     (delivered_seen),
        .exhausted_seen     (exhausted_seen),
        .full_seen          (full_seen)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls per word, quiet stretches, one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready <= (rx_gap == 0);
            if (rx_gap > 0)
                rx_gap--;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                words_taken++;
                if (words_taken % 64 == 0)
                    rx_quiet = ($urandom_range(0, 3) == 0);
                rx_gap = rx_quiet ? 0 : $urandom_range(0, 5);
                // block fills up and must stall its input
                if (words_taken == HOLD_AT_WORD)
                    rx_gap = HOLD_CYCLES;
            end
        end
    end

    // Register write; caller lowers the enable after the last one
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(cfg_t r);
        write_reg(REG_HASH_MOVE, r.hash_move);
        write_reg(REG_KILLER_FIRST, r.killer_first);
        write_reg(REG_KILLER_SECOND, r.killer_second);
        // upper bits are don't-care
        write_reg(REG_KILLERS_PRESENT, {31'($urandom), r.killers_present});
        write_reg(REG_COUNTER_MOVE, r.counter_move);
        write_reg(REG_SPARE, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one command word and hold it until taken, then idle a random while
    task automatic send_word(cmd_t c, logic [31:0] mv, logic cap, int ex, int hist);
        int gap;
        @(negedge clk);
        in_valid <= 1'b1;
        command <= c;
        move_code <= mv;
        is_capture <= cap;
        exchange_value <= 16'(ex);
        history_value <= 17'(hist);
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic int rand_exchange();
        case ($urandom_range(0, 7))
            0:       return 32767;
            1:       return -32767;
            2:       return 0;
            3:       return -1;
            default: return int'($urandom_range(0, 65534)) - 32767;
        endcase
    endfunction

    function automatic int rand_history();
        case ($urandom_range(0, 7))
            0:       return 65535;
            1:       return -65535;
            2:       return 0;
            default: return int'($urandom_range(0, 131070)) - 65535;
        endcase
    endfunction

    // Moves biased towards the registered ones and a small shared pool
    function automatic logic [31:0] pick_move();
        case ($urandom_range(0, 9))
            0:       return cur_regs.hash_move;
            1:       return cur_regs.killer_first;
            2:       return cur_regs.killer_second;
            3:       return cur_regs.counter_move;
            4, 5, 6: return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_cmd(cmd_t c);
        send_word(c, $urandom, 1'($urandom), rand_exchange(), rand_history());
    endtask

    task automatic append_random();
        send_word(CMD_APPEND, pick_move(), ($urandom_range(0, 2) == 0), rand_exchange(),
                  rand_history());
    endtask

    // Mostly clear, fill, drain by takes; sometimes keep the list, sometimes noise
    task automatic run_burst();
        int n_add;
        int roll;
        tx_quiet = ($urandom_range(0, 4) == 0);
        roll = $urandom_range(0, 19);
        if (roll == 0)
        begin
            repeat ($urandom_range(1, 4)) send_cmd(cmd_t'($urandom_range(0, 3)));
        end
        else
        begin
            if (roll > 2)
                send_cmd(CMD_CLEAR);
            n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 10);
            repeat (n_add) append_random();
            repeat (n_add + $urandom_range(0, 2))
            begin
                roll = $urandom_range(0, 19);
                if (roll < 16)
                    send_cmd(CMD_TAKE);
                else if (roll < 19)
                    append_random();
                else
                    send_cmd(CMD_NOP);
            end
        end
    endtask

    // Full list: overflowing appends, appends after takes, then read out to empty
    task automatic fill_to_capacity();
        send_cmd(CMD_CLEAR);
        repeat (LIST_DEPTH + 2) append_random();
        repeat (4) send_cmd(CMD_TAKE);
        repeat (2) append_random();
        repeat (LIST_DEPTH - 3) send_cmd(CMD_TAKE);
    endtask

    // Stop offering and wait for every awaited word, then let a take finish
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Stimulus
    initial
    begin
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = CMD_CLEAR;
        move_code = '0;
        is_capture = 1'b0;
        exchange_value = '0;
        history_value = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: every score band, extremes, a take on an empty list, then takes to empty
        cur_regs.hash_move = 32'h0000_0ABC;
        cur_regs.killer_first = 32'h0000_0005;
        cur_regs.killer_second = 32'h8000_0007;
        cur_regs.killers_present = 1'b1;
        cur_regs.counter_move = 32'h0000_0009;
        load_regs(cur_regs);
        send_cmd(CMD_TAKE);
        send_cmd(CMD_NOP);
        send_word(CMD_APPEND, cur_regs.hash_move, 1'b0, 0, 0);
        send_word(CMD_APPEND, 32'hFFFF_FFFF, 1'b1, 32767, 0);
        send_word(CMD_APPEND, 32'h0000_0000, 1'b1, 0, 0);
        send_word(CMD_APPEND, 32'h1111_1111, 1'b1, -32767, 0);
        send_word(CMD_APPEND, cur_regs.killer_first, 1'b0, 0, 0);
        send_word(CMD_APPEND, cur_regs.killer_second, 1'b0, 0, 0);
        send_word(CMD_APPEND, cur_regs.counter_move, 1'b0, 0, 0);
        // capture that is also a killer counts as a capture
        send_word(CMD_APPEND, cur_regs.killer_first, 1'b1, -3, 0);
        send_word(CMD_APPEND, 32'h2222_2222, 1'b0, 0, 65535);
        send_word(CMD_APPEND, 32'h3333_3333, 1'b0, 0, -65535);
        repeat (11) send_cmd(CMD_TAKE);
        drain();

        // random phases, each under its own register setting
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: cur_regs = '0;
                1: cur_regs = '1;
                default:
                begin
                    cur_regs.hash_move = $urandom_range(0, 1) ? 32'($urandom_range(0, 15))
                                                              : $urandom;
                    cur_regs.killer_first = 32'($urandom_range(0, 15));
                    cur_regs.killer_second = $urandom_range(0, 1) ? 32'($urandom_range(0, 15))
                                                                  : $urandom;
                    cur_regs.killers_present = (p % 2 == 0);
                    cur_regs.counter_move = 32'($urandom_range(0, 15));
                end
            endcase
            load_regs(cur_regs);
            if (p == 3)
                fill_to_capacity();
            while (items_sent < ITEM_TARGET * (p + 1) / PHASES)
                run_burst();
            drain();
        end

        $display("Covered %0d command words under %0d register settings, list depth %0d.",
                 items_sent, PHASES + 1, LIST_DEPTH);
        $display("Seen %0d moves handed out, %0d takes on an empty list, %0d appends refused.",
                 delivered_seen, exhausted_seen, full_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
